// ----- rtl/rqme_pkg.sv -----
// ----------------------------------------------------------------------------
// rqme_pkg
// Shared opcodes, codes and the command type of the queue machine core.
// ----------------------------------------------------------------------------
package rqme_pkg;

    // Operation codes.
    localparam logic [4:0] OP_LOADX    = 5'd0;
    localparam logic [4:0] OP_SWAP     = 5'd1;
    localparam logic [4:0] OP_ROTREGL  = 5'd2;
    localparam logic [4:0] OP_ROTREGR  = 5'd3;
    localparam logic [4:0] OP_READINT  = 5'd4;
    localparam logic [4:0] OP_READCHAR = 5'd5;
    localparam logic [4:0] OP_OUTINT   = 5'd6;
    localparam logic [4:0] OP_OUTCHAR  = 5'd7;
    localparam logic [4:0] OP_JZ       = 5'd8;
    localparam logic [4:0] OP_JNZ      = 5'd9;
    localparam logic [4:0] OP_CLEARQ   = 5'd10;
    localparam logic [4:0] OP_ENQ      = 5'd11;
    localparam logic [4:0] OP_DEQ      = 5'd12;
    localparam logic [4:0] OP_ROTQL    = 5'd13;
    localparam logic [4:0] OP_ROTQR    = 5'd14;
    localparam logic [4:0] OP_ADD      = 5'd15;
    localparam logic [4:0] OP_SUB      = 5'd16;
    localparam logic [4:0] OP_MUL      = 5'd17;
    localparam logic [4:0] OP_DIV      = 5'd18;

    // Command classes assigned by the front end.
    localparam logic [2:0] CLS_SIMPLE = 3'd0;
    localparam logic [2:0] CLS_DEQ    = 3'd1;
    localparam logic [2:0] CLS_ROT    = 3'd2;
    localparam logic [2:0] CLS_MUL    = 3'd3;
    localparam logic [2:0] CLS_DIV    = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_DIV0  = 2'd3;

    // Classified command passed from the front end to the execute stage.
    typedef struct packed {
        logic [2:0]  cls;
        logic [4:0]  opcode;
        logic [63:0] imm;
        logic [15:0] count;
    } t_cmd;

endpackage

// ----- rtl/rqme_if.sv -----
// ----------------------------------------------------------------------------
// rqme_if
// Valid/ready channels for items entering and results leaving the core.
// ----------------------------------------------------------------------------
interface rqme_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         opcode;
    logic signed [63:0] immediate_value;
    logic [15:0]        rotate_count;

    modport source (output valid, output opcode, output immediate_value,
                    output rotate_count, input ready);
    modport sink   (input valid, input opcode, input immediate_value,
                    input rotate_count, output ready);
endinterface

interface rqme_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] out_value;
    logic [1:0]         out_kind;
    logic               branch_taken;
    logic [1:0]         status_code;
    logic [8:0]         queue_count;

    modport source (output valid, output out_value, output out_kind,
                    output branch_taken, output status_code, output queue_count,
                    input ready);
    modport sink   (input valid, input out_value, input out_kind,
                    input branch_taken, input status_code, input queue_count,
                    output ready);
endinterface

// ----- rtl/rqme_front.sv -----
// ----------------------------------------------------------------------------
// rqme_front
// Accepts items, classifies them and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module rqme_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rqme_in_if.sink         i_in,
    output logic            o_cmd_valid,
    output rqme_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_take
);

    rqme_pkg::t_cmd r_ent [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;
    rqme_pkg::t_cmd in_cmd;

    // Sort an opcode by the execute path it needs.
    function automatic logic [2:0] f_class(input logic [4:0] op);
        logic [2:0] c;
        case (op)
            rqme_pkg::OP_DEQ:   c = rqme_pkg::CLS_DEQ;
            rqme_pkg::OP_ROTQL: c = rqme_pkg::CLS_ROT;
            rqme_pkg::OP_ROTQR: c = rqme_pkg::CLS_ROT;
            rqme_pkg::OP_MUL:   c = rqme_pkg::CLS_MUL;
            rqme_pkg::OP_DIV:   c = rqme_pkg::CLS_DIV;
            default:            c = rqme_pkg::CLS_SIMPLE;
        endcase
        return c;
    endfunction

    // Build the classified command from the incoming item.
    always_comb begin
        in_cmd.cls    = f_class(i_in.opcode);
        in_cmd.opcode = i_in.opcode;
        in_cmd.imm    = i_in.immediate_value;
        in_cmd.count  = i_in.rotate_count;
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign pop         = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_ent[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= in_cmd;
        end
    end

    // Queue pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/rqme_exec.sv -----
// ----------------------------------------------------------------------------
// rqme_exec
// Executes commands on X, Y, Z and the word queue; iterative multiply,
// divide and queue rotation; registered result output.
// ----------------------------------------------------------------------------
module rqme_exec #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  rqme_pkg::t_cmd  i_cmd,
    output logic            o_cmd_take,
    rqme_out_if.source      o_out
);

    localparam int IW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEQ  = 4'd1;
    localparam logic [3:0] ST_RMOD = 4'd2;
    localparam logic [3:0] ST_RRD  = 4'd3;
    localparam logic [3:0] ST_RWR  = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_DFIX = 4'd7;

    logic [63:0]   r_mem [QUEUE_DEPTH];
    logic [63:0]   r_rd;

    logic [3:0]    r_state, n_state;
    logic [63:0]   r_x, n_x, r_y, n_y, r_z, n_z;
    logic [IW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [6:0]    r_iter, n_iter;
    logic          r_left, n_left;
    logic [15:0]   r_cnt, n_cnt;
    logic [FW:0]   r_rem, n_rem;
    logic [63:0]   r_a, n_a, r_b, n_b, r_acc, n_acc, r_drem, n_drem;
    logic          r_negq, n_negq, r_negr, n_negr;

    logic          r_ovalid, n_ovalid;
    logic [63:0]   r_oval, n_oval;
    logic [1:0]    r_okind, n_okind;
    logic          r_otaken, n_otaken;
    logic [1:0]    r_ostat, n_ostat;
    logic [8:0]    r_ocount, n_ocount;

    logic          we;
    logic [IW-1:0] waddr;
    logic [63:0]   wdata;
    logic [IW-1:0] raddr;
    logic          fin;
    logic [63:0]   f_val;
    logic [1:0]    f_kind;
    logic          f_taken;
    logic [1:0]    f_stat;
    logic          slot_free;
    logic [FW:0]   mod_t;
    logic [64:0]   div_t;
    logic [63:0]   mul_acc;
    logic [IW-1:0] prev_head;

    // Circular index: the sum is always below twice the depth.
    function automatic logic [IW-1:0] f_wrap(input logic [FW:0] s);
        logic [FW:0] d;
        d = s - (FW+1)'(QUEUE_DEPTH);
        return (s >= (FW+1)'(QUEUE_DEPTH)) ? d[IW-1:0] : s[IW-1:0];
    endfunction

    assign slot_free = !r_ovalid || o_out.ready;

    // Queue memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[raddr];
    end

    // Command sequencing and datapath.
    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_head   = r_head;
        n_fill   = r_fill;
        n_iter   = r_iter;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_a      = r_a;
        n_b      = r_b;
        n_acc    = r_acc;
        n_drem   = r_drem;
        n_negq   = r_negq;
        n_negr   = r_negr;
        we       = 1'b0;
        waddr    = r_head;
        wdata    = r_z;
        raddr    = r_head;
        fin      = 1'b0;
        f_val    = 64'd0;
        f_kind   = rqme_pkg::KIND_NONE;
        f_taken  = 1'b0;
        f_stat   = rqme_pkg::STAT_OK;
        o_cmd_take = 1'b0;
        mod_t    = {r_rem[FW-1:0], r_cnt[15]};
        div_t    = {r_drem, r_a[63]};
        mul_acc  = r_b[0] ? (r_acc + r_a) : r_acc;
        prev_head = f_wrap((FW+1)'(r_head) + (FW+1)'(QUEUE_DEPTH - 1));

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_cmd_take = 1'b1;
                    case (i_cmd.cls)
                        rqme_pkg::CLS_SIMPLE: begin
                            fin = 1'b1;
                            case (i_cmd.opcode)
                                rqme_pkg::OP_LOADX, rqme_pkg::OP_READINT: begin
                                    n_x = i_cmd.imm;
                                end
                                rqme_pkg::OP_SWAP: begin
                                    n_x = r_y;
                                    n_y = r_x;
                                end
                                rqme_pkg::OP_ROTREGL: begin
                                    n_x = r_y;
                                    n_y = r_z;
                                    n_z = r_x;
                                end
                                rqme_pkg::OP_ROTREGR: begin
                                    n_z = r_y;
                                    n_y = r_x;
                                    n_x = r_z;
                                end
                                rqme_pkg::OP_READCHAR: begin
                                    n_x = {{56{i_cmd.imm[7]}}, i_cmd.imm[7:0]};
                                end
                                rqme_pkg::OP_OUTINT: begin
                                    f_val  = r_z;
                                    f_kind = rqme_pkg::KIND_INT;
                                end
                                rqme_pkg::OP_OUTCHAR: begin
                                    f_val  = {56'd0, r_z[7:0]};
                                    f_kind = rqme_pkg::KIND_CHAR;
                                end
                                rqme_pkg::OP_JZ: begin
                                    f_taken = (r_z == 64'd0);
                                end
                                rqme_pkg::OP_JNZ: begin
                                    f_taken = (r_z != 64'd0);
                                end
                                rqme_pkg::OP_CLEARQ: begin
                                    n_fill = '0;
                                    n_head = '0;
                                end
                                rqme_pkg::OP_ENQ: begin
                                    if (r_fill >= FW'(QUEUE_DEPTH)) begin
                                        f_stat = rqme_pkg::STAT_FULL;
                                    end else begin
                                        we     = 1'b1;
                                        waddr  = f_wrap((FW+1)'(r_head) + (FW+1)'(r_fill));
                                        n_fill = r_fill + FW'(1);
                                    end
                                end
                                rqme_pkg::OP_ADD: begin
                                    n_z = r_x + r_y;
                                end
                                rqme_pkg::OP_SUB: begin
                                    n_z = r_x - r_y;
                                end
                                default: begin
                                end
                            endcase
                        end
                        rqme_pkg::CLS_DEQ: begin
                            if (r_fill == '0) begin
                                fin    = 1'b1;
                                f_stat = rqme_pkg::STAT_EMPTY;
                            end else begin
                                raddr   = r_head;
                                n_state = ST_DEQ;
                            end
                        end
                        rqme_pkg::CLS_ROT: begin
                            if (r_fill == '0) begin
                                fin = 1'b1;
                            end else begin
                                n_cnt   = i_cmd.count;
                                n_rem   = '0;
                                n_iter  = 7'd16;
                                n_left  = (i_cmd.opcode == rqme_pkg::OP_ROTQL);
                                n_state = ST_RMOD;
                            end
                        end
                        rqme_pkg::CLS_MUL: begin
                            n_a     = r_x;
                            n_b     = r_y;
                            n_acc   = 64'd0;
                            n_iter  = 7'd64;
                            n_state = ST_MUL;
                        end
                        rqme_pkg::CLS_DIV: begin
                            if (r_y == 64'd0) begin
                                fin    = 1'b1;
                                f_stat = rqme_pkg::STAT_DIV0;
                            end else begin
                                n_a     = r_x[63] ? (64'd0 - r_x) : r_x;
                                n_b     = r_y[63] ? (64'd0 - r_y) : r_y;
                                n_drem  = 64'd0;
                                n_negq  = r_x[63] ^ r_y[63];
                                n_negr  = r_x[63];
                                n_iter  = 7'd64;
                                n_state = ST_DIV;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEQ: begin
                n_x     = r_rd;
                n_head  = f_wrap((FW+1)'(r_head) + (FW+1)'(1));
                n_fill  = r_fill - FW'(1);
                fin     = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RMOD: begin
                // One remainder bit of the rotate count per cycle.
                if (mod_t >= {1'b0, r_fill}) begin
                    mod_t = mod_t - {1'b0, r_fill};
                end
                n_rem  = mod_t;
                n_cnt  = {r_cnt[14:0], 1'b0};
                n_iter = r_iter - 7'd1;
                if (r_iter == 7'd1) begin
                    if (mod_t == '0) begin
                        fin     = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RRD;
                    end
                end
            end
            ST_RRD: begin
                raddr   = r_left ? r_head
                                 : f_wrap((FW+1)'(r_head) + (FW+1)'(r_fill - FW'(1)));
                n_state = ST_RWR;
            end
            ST_RWR: begin
                // Move one word between the ends of the queue.
                we    = 1'b1;
                wdata = r_rd;
                if (r_left) begin
                    waddr  = f_wrap((FW+1)'(r_head) + (FW+1)'(r_fill));
                    n_head = f_wrap((FW+1)'(r_head) + (FW+1)'(1));
                end else begin
                    waddr  = prev_head;
                    n_head = prev_head;
                end
                n_rem = r_rem - (FW+1)'(1);
                if (r_rem == (FW+1)'(1)) begin
                    fin     = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RRD;
                end
            end
            ST_MUL: begin
                // Shift-and-add, one multiplier bit per cycle.
                n_acc  = mul_acc;
                n_a    = {r_a[62:0], 1'b0};
                n_b    = {1'b0, r_b[63:1]};
                n_iter = r_iter - 7'd1;
                if (r_iter == 7'd1) begin
                    n_z     = mul_acc;
                    fin     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_a = {r_a[62:0], 1'b0};
                if (div_t >= {1'b0, r_b}) begin
                    div_t  = div_t - {1'b0, r_b};
                    n_a[0] = 1'b1;
                end
                n_drem = div_t[63:0];
                n_iter = r_iter - 7'd1;
                if (r_iter == 7'd1) begin
                    n_state = ST_DFIX;
                end
            end
            ST_DFIX: begin
                n_z     = r_negq ? (64'd0 - r_a) : r_a;
                n_y     = r_negr ? (64'd0 - r_drem) : r_drem;
                fin     = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Result register.
        n_ovalid = r_ovalid && !o_out.ready;
        n_oval   = r_oval;
        n_okind  = r_okind;
        n_otaken = r_otaken;
        n_ostat  = r_ostat;
        n_ocount = r_ocount;
        if (fin) begin
            n_ovalid = 1'b1;
            n_oval   = f_val;
            n_okind  = f_kind;
            n_otaken = f_taken;
            n_ostat  = f_stat;
            n_ocount = 9'(n_fill);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_x      <= 64'd0;
            r_y      <= 64'd0;
            r_z      <= 64'd0;
            r_head   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_iter   <= n_iter;
        r_left   <= n_left;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_drem   <= n_drem;
        r_negq   <= n_negq;
        r_negr   <= n_negr;
        r_oval   <= n_oval;
        r_okind  <= n_okind;
        r_otaken <= n_otaken;
        r_ostat  <= n_ostat;
        r_ocount <= n_ocount;
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.out_value    = r_oval;
    assign o_out.out_kind     = r_okind;
    assign o_out.branch_taken = r_otaken;
    assign o_out.status_code  = r_ostat;
    assign o_out.queue_count  = r_ocount;

`ifndef SYNTHESIS
    // The fill count never exceeds the queue depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    // A command is only taken by an idle sequencer.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (r_state == ST_IDLE))
        else $error("command taken while busy");

    // A result is never overwritten before it is delivered.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_oval)
                                        && $stable(r_ostat)))
        else $error("pending result lost");

    // A multi-cycle command leaves the idle state only when taken.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !o_cmd_take) |=> (r_state == ST_IDLE))
        else $error("sequencer started without a command");
`endif

endmodule

// ----- rtl/register_queue_machine_execute.sv -----
// Register, I/O and enqueue items finish directly from idle; dequeue adds a read
// step; multiply takes one multiplier bit a cycle, divide one quotient bit a cycle.
// Queue rotate reduces the count mod fill bit by bit, then moves each word with a
// read and a write step, set by the single read and write port of the queue memory.
// One item is executed at a time; a two-entry command queue keeps input open.
// Reset (synchronous, active low) clears X, Y, Z, queue head and fill at once.
// ----------------------------------------------------------------------------
// register_queue_machine_execute
// Top level of the queue machine core: front end, command queue and executor.
// ----------------------------------------------------------------------------
module register_queue_machine_execute #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rqme_in_if.sink    i_in,
    rqme_out_if.source o_out
);

    logic           cmd_valid;
    logic           cmd_take;
    rqme_pkg::t_cmd cmd;

    // Item intake and classification.
    rqme_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Execution and result delivery.
    rqme_exec #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_out       (o_out)
    );

endmodule

// ----- dv/tb_register_queue_machine_execute.sv -----
// ----------------------------------------------------------------------------
// tb_register_queue_machine_execute
// Drives the queue machine core with a table of directed items and then with
// random programs, and checks each result against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_register_queue_machine_execute;

    localparam int DEPTH = 256;
    localparam int N_ITEMS = 650;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  kind;
        logic        taken;
        logic [1:0]  status;
        logic [8:0]  count;
    } t_result;

    typedef struct {
        logic [4:0]  op;
        logic [63:0] imm;
        logic [15:0] cnt;
        logic        has_exp;
        t_result     exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rqme_in_if  in_ch ();
    rqme_out_if out_ch ();

    register_queue_machine_execute #(.QUEUE_DEPTH(DEPTH)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Predictor state.
    logic [63:0] px, py, pz;
    logic [63:0] pq [DEPTH];
    int unsigned phead, pfill;

    t_result result_fifo[$];
    logic    rowexp_fifo[$];
    t_result rowval_fifo[$];

    int errors;
    int n_sent;
    int n_checked;
    bit sending_done;
    bit long_hold;

    // Clock.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on result %0d: %s got %h want %h", n_checked, what, got, want);
        errors++;
    endtask

    function automatic int unsigned qslot(input int unsigned off);
        return (phead + off) % DEPTH;
    endfunction

    // Computes the result of one item and advances the predictor state.
    function automatic t_result execute_item(input logic [4:0] op, input logic [63:0] imm,
                                             input logic [15:0] cnt);
        t_result r;
        logic [63:0] t, mx, my, q, rm;
        int unsigned steps;
        r = '0;
        case (op)
            rqme_pkg::OP_LOADX, rqme_pkg::OP_READINT: px = imm;
            rqme_pkg::OP_SWAP: begin
                t = px; px = py; py = t;
            end
            rqme_pkg::OP_ROTREGL: begin
                t = px; px = py; py = pz; pz = t;
            end
            rqme_pkg::OP_ROTREGR: begin
                t = pz; pz = py; py = px; px = t;
            end
            rqme_pkg::OP_READCHAR: px = {{56{imm[7]}}, imm[7:0]};
            rqme_pkg::OP_OUTINT: begin
                r.value = pz; r.kind = rqme_pkg::KIND_INT;
            end
            rqme_pkg::OP_OUTCHAR: begin
                r.value = {56'd0, pz[7:0]}; r.kind = rqme_pkg::KIND_CHAR;
            end
            rqme_pkg::OP_JZ:  r.taken = (pz == 0);
            rqme_pkg::OP_JNZ: r.taken = (pz != 0);
            rqme_pkg::OP_CLEARQ: begin
                pfill = 0; phead = 0;
            end
            rqme_pkg::OP_ENQ: begin
                if (pfill >= DEPTH) r.status = rqme_pkg::STAT_FULL;
                else begin
                    pq[qslot(pfill)] = pz; pfill++;
                end
            end
            rqme_pkg::OP_DEQ: begin
                if (pfill == 0) r.status = rqme_pkg::STAT_EMPTY;
                else begin
                    px = pq[qslot(0)]; phead = qslot(1); pfill--;
                end
            end
            rqme_pkg::OP_ROTQL, rqme_pkg::OP_ROTQR: begin
                if (pfill != 0) begin
                    steps = cnt % pfill;
                    for (int i = 0; i < steps; i++) begin
                        if (op == rqme_pkg::OP_ROTQL) begin
                            t = pq[qslot(0)]; phead = qslot(1); pq[qslot(pfill - 1)] = t;
                        end else begin
                            t = pq[qslot(pfill - 1)]; phead = qslot(DEPTH - 1);
                            pq[qslot(0)] = t;
                        end
                    end
                end
            end
            rqme_pkg::OP_ADD: pz = px + py;
            rqme_pkg::OP_SUB: pz = px - py;
            rqme_pkg::OP_MUL: pz = px * py;
            rqme_pkg::OP_DIV: begin
                if (py == 0) r.status = rqme_pkg::STAT_DIV0;
                else begin
                    mx = px[63] ? -px : px;
                    my = py[63] ? -py : py;
                    q = mx / my;
                    rm = mx % my;
                    if (px[63] != py[63]) q = -q;
                    if (px[63]) rm = -rm;
                    pz = q; py = rm;
                end
            end
            default: ;
        endcase
        r.count = pfill[8:0];
        return r;
    endfunction

    function automatic t_result mk(input logic [63:0] v, input logic [1:0] k,
                                   input logic tk, input logic [1:0] s, input logic [8:0] c);
        t_result r;
        r.value = v; r.kind = k; r.taken = tk; r.status = s; r.count = c;
        return r;
    endfunction

    // Directed table; expected results typed in where obvious.
    t_row rows[$];
    task automatic add_row(input logic [4:0] op, input logic [63:0] imm,
                           input logic [15:0] cnt, input logic he, input t_result e);
        t_row r;
        r.op = op; r.imm = imm; r.cnt = cnt; r.has_exp = he; r.exp = e;
        rows.push_back(r);
    endtask

    // Drives one item and waits for acceptance.
    task automatic send_item(input logic [4:0] op, input logic [63:0] imm,
                             input logic [15:0] cnt, input logic he, input t_result e);
        t_result p;
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.immediate_value <= imm;
        in_ch.rotate_count <= cnt;
        p = execute_item(op, imm, cnt);
        result_fifo.push_back(p);
        rowexp_fifo.push_back(he);
        rowval_fifo.push_back(e);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic idle_cycles(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7FFF_FFFF_FFFF_FFFF;
            2: v = {64{1'b1}};
            3: v = $urandom_range(0, 20);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [4:0] rand_op();
        int s;
        s = $urandom_range(0, 99);
        if (s < 3) return 5'($urandom_range(19, 31));
        if (s < 18) return rqme_pkg::OP_ENQ;
        if (s < 26) return rqme_pkg::OP_DEQ;
        if (s < 34) return $urandom_range(0, 1) ? rqme_pkg::OP_ROTQL : rqme_pkg::OP_ROTQR;
        if (s < 40) return $urandom_range(0, 1) ? rqme_pkg::OP_MUL : rqme_pkg::OP_DIV;
        if (s < 41) return rqme_pkg::OP_CLEARQ;
        return 5'($urandom_range(0, 18));
    endfunction

    // Stimulus.
    initial begin
        t_result z;
        int burst;
        errors = 0; n_sent = 0; n_checked = 0; sending_done = 0; long_hold = 0;
        px = 0; py = 0; pz = 0; phead = 0; pfill = 0;
        z = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.immediate_value = '0;
        in_ch.rotate_count = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(rqme_pkg::OP_OUTINT, 0, 0, 1,
                mk(0, rqme_pkg::KIND_INT, 0, rqme_pkg::STAT_OK, 0));
        add_row(rqme_pkg::OP_JZ, 0, 0, 1,
                mk(0, rqme_pkg::KIND_NONE, 1, rqme_pkg::STAT_OK, 0));
        add_row(rqme_pkg::OP_DEQ, 0, 0, 1,
                mk(0, rqme_pkg::KIND_NONE, 0, rqme_pkg::STAT_EMPTY, 0));
        add_row(rqme_pkg::OP_DIV, 0, 0, 1,
                mk(0, rqme_pkg::KIND_NONE, 0, rqme_pkg::STAT_DIV0, 0));
        add_row(rqme_pkg::OP_ROTQL, 0, 16'hFFFF, 1,
                mk(0, rqme_pkg::KIND_NONE, 0, rqme_pkg::STAT_OK, 0));
        add_row(rqme_pkg::OP_LOADX, 64'h8000_0000_0000_0000, 0, 0, z);
        add_row(rqme_pkg::OP_SWAP, 0, 0, 0, z);
        add_row(rqme_pkg::OP_READINT, {64{1'b1}}, 0, 0, z);
        add_row(rqme_pkg::OP_SWAP, 0, 0, 0, z);
        add_row(rqme_pkg::OP_DIV, 0, 0, 0, z);        // most negative by -1 wraps
        add_row(rqme_pkg::OP_OUTINT, 0, 0, 0, z);
        add_row(rqme_pkg::OP_READCHAR, 64'h1234_5678_9ABC_DEF0, 0, 0, z);
        add_row(rqme_pkg::OP_READCHAR, 64'h7F, 0, 0, z);
        add_row(rqme_pkg::OP_ROTREGL, 0, 0, 0, z);
        add_row(rqme_pkg::OP_ROTREGR, 0, 0, 0, z);
        add_row(rqme_pkg::OP_ROTREGL, 0, 0, 0, z);
        add_row(rqme_pkg::OP_OUTCHAR, 0, 0, 0, z);
        add_row(rqme_pkg::OP_JNZ, 0, 0, 0, z);
        add_row(rqme_pkg::OP_ENQ, 0, 0, 0, z);
        add_row(rqme_pkg::OP_ADD, 0, 0, 0, z);
        add_row(rqme_pkg::OP_ENQ, 0, 0, 0, z);
        add_row(rqme_pkg::OP_SUB, 0, 0, 0, z);
        add_row(rqme_pkg::OP_ENQ, 0, 0, 0, z);
        add_row(rqme_pkg::OP_MUL, 0, 0, 0, z);
        add_row(rqme_pkg::OP_ROTQR, 0, 16'd5, 0, z);
        add_row(rqme_pkg::OP_ROTQL, 0, 16'hFFFF, 0, z);
        add_row(rqme_pkg::OP_DEQ, 0, 0, 0, z);
        add_row(rqme_pkg::OP_CLEARQ, 0, 0, 0, z);
        add_row(5'd31, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, z);
        foreach (rows[i]) send_item(rows[i].op, rows[i].imm, rows[i].cnt,
                                    rows[i].has_exp, rows[i].exp);

        // Fill the queue to capacity and beyond, with a long receiver hold.
        long_hold = 1;
        for (int i = 0; i < DEPTH + 3; i++) begin
            send_item(rqme_pkg::OP_ADD, 0, 0, 0, z);
            send_item(rqme_pkg::OP_ENQ, 0, 0, 0, z);
        end
        long_hold = 0;
        send_item(rqme_pkg::OP_ROTQL, 0, 16'($urandom_range(0, 255)), 0, z);
        send_item(rqme_pkg::OP_ROTQR, 0, 16'hFFFF, 0, z);
        idle_cycles(1);
        // Pause until all results are in.
        while (result_fifo.size() != 0) @(posedge i_clk);
        send_item(rqme_pkg::OP_CLEARQ, 0, 0, 0, z);

        // Random programs in bursts.
        while (n_sent < N_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                logic [4:0] op;
                op = rand_op();
                send_item(op, rand64(), 16'($urandom_range(0, 1) ? $urandom_range(0, 40)
                                                              : $urandom_range(0, 65535)),
                          0, z);
            end
            if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 6));
        end
        in_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // Receiver stall pattern, with a long hold while the queue fills.
    initial begin
        int hold;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(posedge i_clk);
                out_ch.ready <= 1'b1;
                while (long_hold) @(posedge i_clk);
            end else if (n_sent % 100 < 30) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result e, v;
        logic he;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (result_fifo.size() == 0) begin
                report_mismatch("result with no expectation waiting", 64'd0, 64'd0);
            end else begin
                e = result_fifo.pop_front();
                he = rowexp_fifo.pop_front();
                v = rowval_fifo.pop_front();
                if (he && v != e)
                    report_mismatch("predictor against table value", e.value, v.value);
                if (out_ch.out_value !== e.value)
                    report_mismatch("out_value", out_ch.out_value, e.value);
                if (out_ch.out_kind !== e.kind)
                    report_mismatch("out_kind", 64'(out_ch.out_kind), 64'(e.kind));
                if (out_ch.branch_taken !== e.taken)
                    report_mismatch("branch_taken", 64'(out_ch.branch_taken), 64'(e.taken));
                if (out_ch.status_code !== e.status)
                    report_mismatch("status_code", 64'(out_ch.status_code), 64'(e.status));
                if (out_ch.queue_count !== e.count)
                    report_mismatch("queue_count", 64'(out_ch.queue_count), 64'(e.count));
            end
            n_checked++;
        end
    end

    // End of run.
    initial begin
        wait (sending_done);
        while (result_fifo.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("Ran %0d items over every opcode, queue full and empty, rotations,", n_sent);
        $display("divide by zero and overflow; %0d results checked.", n_checked);
        if (errors == 0 && result_fifo.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #5000000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
